@@ rtl/sctok_pkg.sv @@
// ----------------------------------------------------------------------------
// sctok_pkg
// Shared types, constants and helpers for the shell command tokenizer.
// ----------------------------------------------------------------------------
package sctok_pkg;

   localparam int MAX_TOKENS = 1024;
   localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
   localparam int NUM_W      = 10;
   localparam int WIDE_W     = CNT_W + NUM_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [NUM_W-1:0] FIELD_TOP = '1;
   localparam logic [CNT_W-1:0] LIMIT_TOP = CNT_W'(MAX_TOKENS - 1);
   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_TOKENS);

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_QUOTE = 2'd1,
      KIND_OPER  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OPEN_QUOTE = 2'd1,
      ST_SATURATED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WORD  = 2'd1,
      MODE_QUOTE = 2'd2,
      MODE_OPER  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CLS_BLANK = 3'd0,
      CLS_QUOTE = 3'd1,
      CLS_OPER  = 3'd2,
      CLS_OTHER = 3'd3,
      CLS_EOL   = 3'd4
   } class_type;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_char;
      logic [1:0]       token_kind;
      logic             new_token;
      logic [NUM_W-1:0] token_number;
      logic             line_done;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic [7:0] character;
      class_type  cls;
   } entry_type;

   function automatic logic [NUM_W-1:0] cap_field(logic [CNT_W-1:0] v);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(v);
      return (wide > WIDE_W'(FIELD_TOP)) ? FIELD_TOP : wide[NUM_W-1:0];
   endfunction

endpackage

@@ rtl/sctok_front.sv @@
// ----------------------------------------------------------------------------
// sctok_front
// Accepts request words and classifies each character for the lexer.
// ----------------------------------------------------------------------------
module sctok_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sctok_pkg::req_type   req_payload,
   input  logic                 q_ready,
   output logic                 q_push,
   output sctok_pkg::entry_type q_entry
);

   sctok_pkg::class_type cls;
   logic [7:0]           ch;

   assign ch = req_payload.character;

   always_comb begin
      if (req_payload.end_of_line) begin
         cls = sctok_pkg::CLS_EOL;
      end else if (ch == sctok_pkg::CH_SPACE || ch == sctok_pkg::CH_TAB ||
                   ch == sctok_pkg::CH_NL) begin
         cls = sctok_pkg::CLS_BLANK;
      end else if (ch == sctok_pkg::CH_SQUOTE || ch == sctok_pkg::CH_DQUOTE) begin
         cls = sctok_pkg::CLS_QUOTE;
      end else if (ch == sctok_pkg::CH_LT || ch == sctok_pkg::CH_GT ||
                   ch == sctok_pkg::CH_PIPE) begin
         cls = sctok_pkg::CLS_OPER;
      end else begin
         cls = sctok_pkg::CLS_OTHER;
      end
   end

   assign req_ready         = q_ready;
   assign q_push            = req_valid & q_ready;
   assign q_entry.character = ch;
   assign q_entry.cls       = cls;

endmodule

@@ rtl/sctok_queue.sv @@
// ----------------------------------------------------------------------------
// sctok_queue
// Two-entry queue between classifier and lexer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module sctok_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sctok_pkg::entry_type push_entry,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 head_valid,
   output sctok_pkg::entry_type head_entry
);

   localparam int PTR_W = $clog2(sctok_pkg::QUEUE_DEPTH);
   localparam int FILL_W = $clog2(sctok_pkg::QUEUE_DEPTH + 1);

   sctok_pkg::entry_type slot_ff [sctok_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(sctok_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sctok_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sctok_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/sctok_back.sv @@
// ----------------------------------------------------------------------------
// sctok_back
// Lexer state machine: tracks token mode and count, registers result words.
// ----------------------------------------------------------------------------
module sctok_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  sctok_pkg::entry_type head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sctok_pkg::rsp_type   rsp_payload
);

   sctok_pkg::mode_type          mode_ff, mode_in;
   logic [7:0]                   open_quote_ff, open_quote_in;
   logic [7:0]                   op_char_ff, op_char_in;
   logic [1:0]                   op_len_ff, op_len_in;
   logic [sctok_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                         sat_ff, sat_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   sctok_pkg::rsp_type           rsp_payload_ff, rsp_payload_in;

   logic [sctok_pkg::NUM_W-1:0]  cur_idx, start_idx;
   logic [sctok_pkg::CNT_W-1:0]  start_count;
   logic                         start_sat, has_room;
   logic [7:0]                   ch;
   sctok_pkg::rsp_type           res;

   assign ch   = head_entry.character;
   assign pop  = head_valid & (~rsp_valid_ff | rsp_ready);
   assign has_room = (count_ff < sctok_pkg::MAX_CNT);

   always_comb begin
      if (sat_ff) begin
         cur_idx = sctok_pkg::cap_field(sctok_pkg::LIMIT_TOP);
      end else if (count_ff == '0) begin
         cur_idx = '0;
      end else begin
         cur_idx = sctok_pkg::cap_field(count_ff - sctok_pkg::CNT_W'(1));
      end
      start_idx   = has_room ? sctok_pkg::cap_field(count_ff) :
                               sctok_pkg::cap_field(sctok_pkg::LIMIT_TOP);
      start_count = has_room ? count_ff + sctok_pkg::CNT_W'(1) : count_ff;
      start_sat   = has_room ? sat_ff : 1'b1;
   end

   always_comb begin
      mode_in        = mode_ff;
      open_quote_in  = open_quote_ff;
      op_char_in     = op_char_ff;
      op_len_in      = op_len_ff;
      count_in       = count_ff;
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      res            = '0;
      res.out_char   = ch;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head_entry.cls == sctok_pkg::CLS_EOL) begin
            res.out_char     = '0;
            res.token_number = sctok_pkg::cap_field(count_ff);
            res.line_done    = 1'b1;
            if (mode_ff == sctok_pkg::MODE_QUOTE) begin
               res.status = sctok_pkg::ST_OPEN_QUOTE;
            end else if (sat_ff) begin
               res.status = sctok_pkg::ST_SATURATED;
            end else begin
               res.status = sctok_pkg::ST_OK;
            end
            mode_in       = sctok_pkg::MODE_IDLE;
            open_quote_in = '0;
            op_char_in    = '0;
            op_len_in     = '0;
            count_in      = '0;
            sat_in        = 1'b0;
         end else if (mode_ff == sctok_pkg::MODE_QUOTE) begin
            res.token_kind   = sctok_pkg::KIND_QUOTE;
            res.token_number = cur_idx;
            if (ch == open_quote_ff) begin
               mode_in       = sctok_pkg::MODE_IDLE;
               open_quote_in = '0;
            end
         end else begin
            unique case (head_entry.cls)
               sctok_pkg::CLS_BLANK: begin
                  rsp_valid_in = 1'b0;
                  mode_in      = sctok_pkg::MODE_IDLE;
                  op_char_in   = '0;
                  op_len_in    = '0;
               end
               sctok_pkg::CLS_QUOTE: begin
                  mode_in          = sctok_pkg::MODE_QUOTE;
                  open_quote_in    = ch;
                  op_char_in       = '0;
                  op_len_in        = '0;
                  count_in         = start_count;
                  sat_in           = start_sat;
                  res.token_kind   = sctok_pkg::KIND_QUOTE;
                  res.new_token    = 1'b1;
                  res.token_number = start_idx;
               end
               sctok_pkg::CLS_OPER: begin
                  res.token_kind = sctok_pkg::KIND_OPER;
                  if (mode_ff == sctok_pkg::MODE_OPER && op_len_ff == 2'd1 &&
                      op_char_ff == ch && ch != sctok_pkg::CH_PIPE) begin
                     op_len_in        = 2'd2;
                     res.token_number = cur_idx;
                  end else begin
                     mode_in          = sctok_pkg::MODE_OPER;
                     op_char_in       = ch;
                     op_len_in        = 2'd1;
                     count_in         = start_count;
                     sat_in           = start_sat;
                     res.new_token    = 1'b1;
                     res.token_number = start_idx;
                  end
               end
               default: begin
                  res.token_kind = sctok_pkg::KIND_WORD;
                  if (mode_ff == sctok_pkg::MODE_WORD) begin
                     res.token_number = cur_idx;
                  end else begin
                     mode_in          = sctok_pkg::MODE_WORD;
                     op_char_in       = '0;
                     op_len_in        = '0;
                     count_in         = start_count;
                     sat_in           = start_sat;
                     res.new_token    = 1'b1;
                     res.token_number = start_idx;
                  end
               end
            endcase
         end
         if (rsp_valid_in) begin
            rsp_payload_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= sctok_pkg::MODE_IDLE;
         open_quote_ff <= '0;
         op_char_ff    <= '0;
         op_len_ff     <= '0;
         count_ff      <= '0;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         open_quote_ff <= open_quote_in;
         op_char_ff    <= op_char_in;
         op_len_ff     <= op_len_in;
         count_ff      <= count_in;
         sat_ff        <= sat_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.cls == sctok_pkg::CLS_EOL |=>
         mode_ff == sctok_pkg::MODE_IDLE && count_ff == '0 && !sat_ff)
      else $error("line end did not clear lexer state");

   a_quote_held: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == sctok_pkg::MODE_QUOTE) == (open_quote_ff != '0))
      else $error("open quote inconsistent with mode");

   a_oper_len: assert property (@(posedge clock) disable iff (reset)
      op_len_ff != 2'd0 |-> mode_ff == sctok_pkg::MODE_OPER ||
                            mode_ff == sctok_pkg::MODE_QUOTE)
      else $error("operator length outside operator token");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> count_ff == sctok_pkg::MAX_CNT)
      else $error("saturation flag without full count");

endmodule

@@ rtl/shell_command_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// shell_command_tokenizer_unit
// Streams a command line one character per word and tags each character
// with its token kind, start flag and token index; line end reports status.
// ----------------------------------------------------------------------------
// Sustained rate is one character per clock with no gaps while the receiver
// keeps rsp_ready high. A request word is classified and written into a
// two-entry queue on the edge it is accepted; the lexer pops it once the
// result register is free or being taken and loads its result word there,
// where it is presented until taken. The lexer's mode and token-count update
// sets the rate. Blank characters outside quotes are consumed without
// producing a result word.
module shell_command_tokenizer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sctok_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sctok_pkg::rsp_type  rsp_payload
);

   logic                 q_ready, q_push, q_pop, q_head_valid;
   sctok_pkg::entry_type q_entry, q_head;

   sctok_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   sctok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   sctok_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_entry  (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ verif/tb_shell_command_tokenizer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_command_tokenizer_unit
// Self-checking bench for the shell command tokenizer. Drives words, quoted
// strings, operator runs, blanks, noise and a very long line that fills the
// token counter. Each accepted request updates a local lexer model whose
// results are compared field by field with the response stream, under
// random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_shell_command_tokenizer_unit;

   localparam int EOL_MARK    = 'h100;
   localparam int ITEM_BUDGET = 1100;

   class token_scoreboard;
      sctok_pkg::rsp_type  lex_results_q[$];
      sctok_pkg::mode_type mode;
      logic [7:0]          open_q;
      logic [7:0]          op_ch;
      int unsigned         op_len;
      int unsigned         tok_cnt;
      bit                  sat;
      int unsigned         errors;
      int unsigned         noted;
      int unsigned         checked;
      int unsigned         lines;
      int unsigned         open_lines;
      int unsigned         sat_lines;

      function new();
         clear_line();
         errors     = 0;
         noted      = 0;
         checked    = 0;
         lines      = 0;
         open_lines = 0;
         sat_lines  = 0;
      endfunction

      static function bit is_blank(logic [7:0] c);
         return c == sctok_pkg::CH_SPACE || c == sctok_pkg::CH_TAB ||
                c == sctok_pkg::CH_NL;
      endfunction

      static function bit is_quote(logic [7:0] c);
         return c == sctok_pkg::CH_SQUOTE || c == sctok_pkg::CH_DQUOTE;
      endfunction

      static function bit is_oper(logic [7:0] c);
         return c == sctok_pkg::CH_LT || c == sctok_pkg::CH_GT ||
                c == sctok_pkg::CH_PIPE;
      endfunction

      function void clear_line();
         mode    = sctok_pkg::MODE_IDLE;
         open_q  = '0;
         op_ch   = '0;
         op_len  = 0;
         tok_cnt = 0;
         sat     = 1'b0;
      endfunction

      function logic [sctok_pkg::NUM_W-1:0] clamp(int unsigned v);
         return (v > sctok_pkg::FIELD_TOP) ? sctok_pkg::FIELD_TOP
                                           : v[sctok_pkg::NUM_W-1:0];
      endfunction

      function logic [sctok_pkg::NUM_W-1:0] claim_index();
         if (tok_cnt < sctok_pkg::MAX_TOKENS) begin
            tok_cnt++;
            return clamp(tok_cnt - 1);
         end
         sat = 1'b1;
         return clamp(sctok_pkg::MAX_TOKENS - 1);
      endfunction

      function void note_word(sctok_pkg::req_type w);
         sctok_pkg::rsp_type          r;
         bit                          hit;
         logic [7:0]                  c;
         logic [sctok_pkg::NUM_W-1:0] cur;
         r   = '0;
         hit = 1'b1;
         c   = w.character;
         cur = sat ? clamp(sctok_pkg::MAX_TOKENS - 1)
                   : (tok_cnt == 0 ? '0 : clamp(tok_cnt - 1));
         if (w.end_of_line) begin
            r.line_done    = 1'b1;
            r.token_number = clamp(tok_cnt);
            if (mode == sctok_pkg::MODE_QUOTE) begin
               r.status = sctok_pkg::ST_OPEN_QUOTE;
               open_lines++;
            end else if (sat) begin
               r.status = sctok_pkg::ST_SATURATED;
               sat_lines++;
            end else begin
               r.status = sctok_pkg::ST_OK;
            end
            lines++;
            clear_line();
         end else if (mode == sctok_pkg::MODE_QUOTE) begin
            r.out_char     = c;
            r.token_kind   = sctok_pkg::KIND_QUOTE;
            r.token_number = cur;
            if (c == open_q) begin
               mode   = sctok_pkg::MODE_IDLE;
               open_q = '0;
            end
         end else if (is_blank(c)) begin
            mode   = sctok_pkg::MODE_IDLE;
            op_ch  = '0;
            op_len = 0;
            hit    = 1'b0;
         end else if (is_quote(c)) begin
            mode           = sctok_pkg::MODE_QUOTE;
            open_q         = c;
            op_ch          = '0;
            op_len         = 0;
            r.out_char     = c;
            r.token_kind   = sctok_pkg::KIND_QUOTE;
            r.new_token    = 1'b1;
            r.token_number = claim_index();
         end else if (is_oper(c)) begin
            r.out_char   = c;
            r.token_kind = sctok_pkg::KIND_OPER;
            if (mode == sctok_pkg::MODE_OPER && op_len == 1 && op_ch == c &&
                c != sctok_pkg::CH_PIPE) begin
               op_len         = 2;
               r.token_number = cur;
            end else begin
               mode           = sctok_pkg::MODE_OPER;
               op_ch          = c;
               op_len         = 1;
               r.new_token    = 1'b1;
               r.token_number = claim_index();
            end
         end else begin
            r.out_char   = c;
            r.token_kind = sctok_pkg::KIND_WORD;
            if (mode == sctok_pkg::MODE_WORD) begin
               r.token_number = cur;
            end else begin
               mode           = sctok_pkg::MODE_WORD;
               op_ch          = '0;
               op_len         = 0;
               r.new_token    = 1'b1;
               r.token_number = claim_index();
            end
         end
         if (hit) begin
            lex_results_q.push_back(r);
            noted++;
         end
      endfunction

      function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_word(sctok_pkg::rsp_type got);
         sctok_pkg::rsp_type want;
         if (lex_results_q.size() == 0) begin
            $error("unexpected response word %h", got);
            errors++;
            return;
         end
         want = lex_results_q.pop_front();
         checked++;
         cmp_field("out_char", want.out_char, got.out_char);
         cmp_field("token_kind", want.token_kind, got.token_kind);
         cmp_field("new_token", want.new_token, got.new_token);
         cmp_field("token_number", want.token_number, got.token_number);
         cmp_field("line_done", want.line_done, got.line_done);
         cmp_field("status", want.status, got.status);
      endfunction

      function int unsigned outstanding();
         return lex_results_q.size();
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   sctok_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   sctok_pkg::rsp_type rsp_payload;

   token_scoreboard sb;
   int              burst_left = 0;
   int              rx_tick    = 0;
   int              rx_mode    = 0;
   int              items_sent = 0;

   shell_command_tokenizer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // receiver: checks accepted response words and switches between random stall styles
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_word(rsp_payload);
      end
      rx_tick++;
      if (rx_tick % 97 == 0) begin
         rx_mode = $urandom_range(0, 3);
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (rx_tick % 3 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic sctok_pkg::req_type mk_word(logic [7:0] c, logic e);
      sctok_pkg::req_type w;
      w.character   = c;
      w.end_of_line = e;
      return w;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h61, 8'h7A))
                                         : 8'($urandom_range(0, 255));
      end while (token_scoreboard::is_blank(c) || token_scoreboard::is_quote(c) ||
                 token_scoreboard::is_oper(c));
      return c;
   endfunction

   function automatic logic [7:0] op_char();
      case ($urandom_range(0, 2))
         0: return sctok_pkg::CH_LT;
         1: return sctok_pkg::CH_GT;
         default: return sctok_pkg::CH_PIPE;
      endcase
   endfunction

   task automatic send(input sctok_pkg::req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_word(w);
      items_sent++;
   endtask

   task automatic send_char(input logic [7:0] c);
      send(mk_word(c, 1'b0));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic send_blanks(input int n);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: send_char(sctok_pkg::CH_SPACE);
            1: send_char(sctok_pkg::CH_TAB);
            default: send_char(sctok_pkg::CH_NL);
         endcase
      end
   endtask

   task automatic send_random_line();
      int         n_tok;
      int         len;
      logic [7:0] q;
      logic [7:0] c;
      n_tok = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 3));
      for (int k = 0; k < n_tok; k++) begin
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               len = $urandom_range(1, 6);
               repeat (len) send_char(plain_char());
            end
            3: begin
               q = ($urandom_range(0, 1) == 0) ? sctok_pkg::CH_SQUOTE
                                               : sctok_pkg::CH_DQUOTE;
               send_char(q);
               len = $urandom_range(0, 6);
               repeat (len) begin
                  do c = 8'($urandom_range(0, 255)); while (c == q);
                  send_char(c);
               end
               send_char(q);
            end
            default: begin
               len = $urandom_range(1, 3);
               c   = op_char();
               repeat (len) begin
                  send_char(c);
                  if ($urandom_range(0, 9) >= 6) c = op_char();
               end
            end
         endcase
         if ($urandom_range(0, 9) < 7) send_blanks($urandom_range(1, 3));
      end
      if ($urandom_range(0, 9) == 0) begin
         q = ($urandom_range(0, 1) == 0) ? sctok_pkg::CH_SQUOTE
                                         : sctok_pkg::CH_DQUOTE;
         send_char(q);
         len = $urandom_range(0, 5);
         repeat (len) begin
            do c = 8'($urandom_range(0, 255)); while (c == q);
            send_char(c);
         end
      end
      send(mk_word(8'($urandom_range(0, 255)), 1'b1));
   endtask

   task automatic send_noise_line();
      int n;
      n = $urandom_range(1, 12);
      repeat (n) begin
         send(mk_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0));
      end
      send(mk_word(8'($urandom_range(0, 255)), 1'b1));
   endtask

   // one word per token; fills the token counter, optionally ends in an open quote
   task automatic send_long_line(input int n_tok, input bit open_end);
      bit was_plain;
      was_plain = 1'b0;
      for (int i = 0; i < n_tok; i++) begin
         if (!was_plain && $urandom_range(0, 3) == 0) begin
            send_char(plain_char());
            was_plain = 1'b1;
         end else begin
            send_char(sctok_pkg::CH_PIPE);
            was_plain = 1'b0;
         end
      end
      if (open_end) begin
         send_char(sctok_pkg::CH_DQUOTE);
         send_char(8'h41);
      end
      send(mk_word(8'($urandom_range(0, 255)), 1'b1));
   endtask

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int dir_seq[$];
      dir_seq = '{8'h00, 8'hFF, sctok_pkg::CH_SPACE, sctok_pkg::CH_TAB, sctok_pkg::CH_NL,
                  sctok_pkg::CH_DQUOTE, sctok_pkg::CH_SPACE, sctok_pkg::CH_SQUOTE,
                  sctok_pkg::CH_GT, sctok_pkg::CH_DQUOTE,
                  sctok_pkg::CH_LT, sctok_pkg::CH_LT, sctok_pkg::CH_LT,
                  sctok_pkg::CH_GT, sctok_pkg::CH_GT, sctok_pkg::CH_PIPE,
                  sctok_pkg::CH_PIPE, sctok_pkg::CH_GT, sctok_pkg::CH_PIPE,
                  8'h62, EOL_MARK | 'hFF,
                  sctok_pkg::CH_SQUOTE, 8'h41, EOL_MARK};
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_seq[i]) begin
         send(mk_word(dir_seq[i][7:0], dir_seq[i] >= EOL_MARK));
      end
      drain();

      send_long_line(sctok_pkg::MAX_TOKENS + 2, 1'b0);
      drain();

      while (items_sent < ITEM_BUDGET) begin
         if ($urandom_range(0, 6) == 0) begin
            send_noise_line();
         end else begin
            send_random_line();
         end
         if ($urandom_range(0, 9) == 0) drain();
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Tokenized %0d lines from %0d request words, %0d response words checked.",
               sb.lines, items_sent, sb.checked);
      $display("Lines ending in an open quote: %0d, with a saturated count: %0d.",
               sb.open_lines, sb.sat_lines);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
